[hw/rtl/prc_pkg.sv]
// ----------------------------------------------------------------------------
// prc_pkg
// Shared constants for the polar/rectangular converter: word widths, CORDIC
// arctangent table, gain and angle scaling constants, input form codes.
// ----------------------------------------------------------------------------
package prc_pkg;

  // data word, Q16.16
  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;

  // result angle, Q3.16 radians
  localparam int ANG_WIDTH  = 19;
  localparam int ANG_MAX    = 205887;

  // cordic datapath
  localparam int ITERS        = 30;
  localparam int GUARD_BITS   = 8;
  localparam int CORDIC_WIDTH = DATA_WIDTH + 12;
  localparam int ZW           = 34;

  // gain compensation, 1/K in Q30
  localparam logic [29:0] GAIN_Q30 = 30'h26DD3B6A;

  // pi/2 in Q30
  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

  // degrees Q16.16 to radians Q30, scaled by 2^32
  localparam logic [40:0] DEG2RAD_C = 41'd1228166276394;

  localparam int DEG_TURN    = 360;
  localparam int DEG_QUARTER = 90;

  // input form codes, all others are invalid
  localparam logic [1:0] MODE_RECT  = 2'd0;
  localparam logic [1:0] MODE_POLAR = 2'd1;

  // atan(2^-i) in Q30
  localparam logic [31:0] ATAN_TAB [ITERS] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
    32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
    32'h00100000, 32'h00080000, 32'h00040000, 32'h00020000, 32'h00010000,
    32'h00008000, 32'h00004000, 32'h00002000, 32'h00001000, 32'h00000800,
    32'h00000400, 32'h00000200, 32'h00000100, 32'h00000080, 32'h00000040,
    32'h00000020, 32'h00000010, 32'h00000008, 32'h00000004, 32'h00000002
  };

endpackage

[hw/rtl/polar_rect_converter.sv]
// ----------------------------------------------------------------------------
// polar_rect_converter
// Converts a 2-D vector given in rectangular or polar (degrees) form into
// both forms: saturated x/y and magnitude plus atan2 angle in radians.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: mode, first_value (x or magnitude), second_value
//   (y or angle in degrees), all Q16.16. A transaction is taken on a clock
//   edge with in_valid high and in_stall low.
//   Output channel out_*: x, y, magnitude, angle (Q3.16) and form_error.
//   A transaction is delivered on an edge with out_valid high and out_stall
//   low. An invalid mode gives all zeros with form_error set.
//   Throughput: one transaction per clock while the output is not stalled.
//   Data passes the two 30-stage unrolled cordic pipelines (rotation,
//   then vectoring) plus degree reduction and gain scaling stages.
//   Reset (rst_n low, synchronous) clears all valid bits; payload is not
//   cleared. When the receiver stalls a valid result, the whole pipeline
//   holds and in_stall rises in the same cycle; nothing is dropped and
//   nothing repeats. Bubbles travel through the pipeline and are not squeezed.
// ----------------------------------------------------------------------------
module polar_rect_converter (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic [1:0]                              in_mode,
  input  logic signed [prc_pkg::DATA_WIDTH-1:0]   in_first_value,
  input  logic signed [prc_pkg::DATA_WIDTH-1:0]   in_second_value,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [prc_pkg::DATA_WIDTH-1:0]   out_x_out,
  output logic signed [prc_pkg::DATA_WIDTH-1:0]   out_y_out,
  output logic [prc_pkg::DATA_WIDTH-1:0]          out_magnitude,
  output logic signed [prc_pkg::ANG_WIDTH-1:0]    out_angle_rad,
  output logic                                    out_form_error
);

  localparam int DW  = prc_pkg::DATA_WIDTH;
  localparam int FB  = prc_pkg::FRAC_BITS;
  localparam int AW  = prc_pkg::ANG_WIDTH;
  localparam int HW  = DW - FB;
  localparam int K   = HW + 9;
  localparam int OFS = (1 << (HW - 1)) % prc_pkg::DEG_TURN;
  localparam logic [HW:0] RECIP =
    (HW + 1)'(((64'd1 << K) + 64'(prc_pkg::DEG_TURN - 1)) / 64'(prc_pkg::DEG_TURN));
  localparam int FW  = 7 + FB;
  localparam int ZSW = FW + 21 + 20 + 1;
  localparam int CW  = prc_pkg::CORDIC_WIDTH;
  localparam int ZW  = prc_pkg::ZW;
  localparam int GB  = prc_pkg::GUARD_BITS;
  localparam int N   = prc_pkg::ITERS;
  localparam int SPL = CW / 2;
  localparam int PW  = SPL + 30;
  localparam int SW  = PW + SPL + 1;
  localparam int GSH = 30 + GB;
  localparam int GRW = CW - 7;
  localparam int LAT = 2 * N + 11;

  localparam logic [19:0] D2R_LO = prc_pkg::DEG2RAD_C[19:0];
  localparam logic [20:0] D2R_HI = prc_pkg::DEG2RAD_C[40:20];
  localparam logic [PW-1:0] GAIN_W = PW'(prc_pkg::GAIN_Q30);
  localparam logic signed [ZW-1:0] HALF_PI = ZW'(prc_pkg::HALF_PI_Q30);
  localparam logic signed [ZW-1:0] ZRND = ZW'(8192);

  // gain scaling: round half away from zero of |v| * gain / 2^38
  function automatic logic signed [GRW-1:0] gain_fin(input logic neg,
                                                     input logic [PW-1:0] ph,
                                                     input logic [PW-1:0] pl);
    logic [SW-1:0] sum;
    logic signed [GRW-1:0] mag;
    sum = {1'b0, ph, SPL'(0)} + SW'(pl) + (SW'(1) << (GSH - 1));
    mag = $signed(GRW'(sum >> GSH));
    return neg ? -mag : mag;
  endfunction

  // clamp to the signed data range
  function automatic logic signed [DW-1:0] sat_dw(input logic signed [GRW-1:0] v);
    if (v[GRW-1:DW-1] == '0 || v[GRW-1:DW-1] == '1) begin
      return v[DW-1:0];
    end
    return v[GRW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
  endfunction

  // global advance and valid pipeline
  logic           en;
  logic [LAT-1:0] valid_r;

  assign en        = !valid_r[LAT-1] || !out_stall;
  assign in_stall  = !en;
  assign out_valid = valid_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[LAT-2:0], in_valid};
    end
  end

  // stage 0: input register
  logic [1:0]           s0_mode_r;
  logic signed [DW-1:0] s0_a_r, s0_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s0_mode_r <= in_mode;
      s0_a_r    <= in_first_value;
      s0_b_r    <= in_second_value;
    end
  end

  // stage 1: whole degrees offset to unsigned, quotient by 360 via reciprocal
  logic [HW-1:0] s1_u_nxt;
  logic [2*HW:0] s1_prod;
  logic [1:0]           s1_mode_r;
  logic signed [DW-1:0] s1_a_r, s1_b_r;
  logic [HW-1:0]        s1_u_r, s1_q_r;

  assign s1_u_nxt = {~s0_b_r[DW-1], s0_b_r[DW-2:FB]};
  assign s1_prod  = (2*HW+1)'(s1_u_nxt) * (2*HW+1)'(RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_mode_r <= s0_mode_r;
      s1_a_r    <= s0_a_r;
      s1_b_r    <= s0_b_r;
      s1_u_r    <= s1_u_nxt;
      s1_q_r    <= HW'(s1_prod >> K);
    end
  end

  // stage 2: remainder, undo the offset, split into quadrant and fraction
  logic [HW-1:0] s2_rem;
  logic [9:0]    s2_adj;
  logic [8:0]    s2_deg;
  logic [1:0]    s2_quad_nxt;
  logic [6:0]    s2_fh;
  logic [1:0]           s2_mode_r;
  logic signed [DW-1:0] s2_a_r, s2_b_r;
  logic [1:0]           s2_quad_r;
  logic [FW-1:0]        s2_f_r;

  always_comb begin
    s2_rem = s1_u_r - HW'(s1_q_r * HW'(prc_pkg::DEG_TURN));
    s2_adj = {1'b0, s2_rem[8:0]} - 10'(OFS);
    s2_deg = s2_adj[9] ? s2_adj[8:0] + 9'(prc_pkg::DEG_TURN) : s2_adj[8:0];
    if (s2_deg >= 9'(3 * prc_pkg::DEG_QUARTER)) begin
      s2_quad_nxt = 2'd3;
      s2_fh       = 7'(s2_deg - 9'(3 * prc_pkg::DEG_QUARTER));
    end else if (s2_deg >= 9'(2 * prc_pkg::DEG_QUARTER)) begin
      s2_quad_nxt = 2'd2;
      s2_fh       = 7'(s2_deg - 9'(2 * prc_pkg::DEG_QUARTER));
    end else if (s2_deg >= 9'(prc_pkg::DEG_QUARTER)) begin
      s2_quad_nxt = 2'd1;
      s2_fh       = 7'(s2_deg - 9'(prc_pkg::DEG_QUARTER));
    end else begin
      s2_quad_nxt = 2'd0;
      s2_fh       = s2_deg[6:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_mode_r <= s1_mode_r;
      s2_a_r    <= s1_a_r;
      s2_b_r    <= s1_b_r;
      s2_quad_r <= s2_quad_nxt;
      s2_f_r    <= {s2_fh, s1_b_r[FB-1:0]};
    end
  end

  // stage 3: degree to radian partial products
  logic [1:0]           s3_mode_r;
  logic signed [DW-1:0] s3_a_r, s3_b_r;
  logic [1:0]           s3_quad_r;
  logic [FW+19:0]       s3_pl_r;
  logic [FW+20:0]       s3_ph_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_mode_r <= s2_mode_r;
      s3_a_r    <= s2_a_r;
      s3_b_r    <= s2_b_r;
      s3_quad_r <= s2_quad_r;
      s3_pl_r   <= (FW+20)'(s2_f_r) * (FW+20)'(D2R_LO);
      s3_ph_r   <= (FW+21)'(s2_f_r) * (FW+21)'(D2R_HI);
    end
  end

  // rotation cordic, entry stage plus one stage per iteration
  logic [ZSW-1:0] s4_sum;
  logic signed [CW-1:0] rot_x_r [0:N];
  logic signed [CW-1:0] rot_y_r [0:N];
  logic signed [ZW-1:0] rot_z_r [0:N];
  logic [1:0]           rot_mode_r [0:N];
  logic signed [DW-1:0] rot_a_r [0:N];
  logic signed [DW-1:0] rot_b_r [0:N];
  logic [1:0]           rot_quad_r [0:N];

  assign s4_sum = {1'b0, s3_ph_r, 20'd0} + ZSW'(s3_pl_r) + (ZSW'(1) << 31);

  always_ff @(posedge clk) begin
    if (en) begin
      rot_x_r[0]    <= CW'(s3_a_r) <<< GB;
      rot_y_r[0]    <= '0;
      rot_z_r[0]    <= $signed(ZW'(s4_sum >> 32));
      rot_mode_r[0] <= s3_mode_r;
      rot_a_r[0]    <= s3_a_r;
      rot_b_r[0]    <= s3_b_r;
      rot_quad_r[0] <= s3_quad_r;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_rot
    localparam logic signed [ZW-1:0] ATAN = ZW'(prc_pkg::ATAN_TAB[i]);
    logic signed [CW-1:0] dx, dy;

    assign dx = rot_y_r[i] >>> i;
    assign dy = rot_x_r[i] >>> i;

    // rotate toward zero residual angle
    always_ff @(posedge clk) begin
      if (en) begin
        if (!rot_z_r[i][ZW-1]) begin
          rot_x_r[i+1] <= rot_x_r[i] - dx;
          rot_y_r[i+1] <= rot_y_r[i] + dy;
          rot_z_r[i+1] <= rot_z_r[i] - ATAN;
        end else begin
          rot_x_r[i+1] <= rot_x_r[i] + dx;
          rot_y_r[i+1] <= rot_y_r[i] - dy;
          rot_z_r[i+1] <= rot_z_r[i] + ATAN;
        end
        rot_mode_r[i+1] <= rot_mode_r[i];
        rot_a_r[i+1]    <= rot_a_r[i];
        rot_b_r[i+1]    <= rot_b_r[i];
        rot_quad_r[i+1] <= rot_quad_r[i];
      end
    end
  end

  // gain stage 1: magnitudes split into partial products
  logic [CW-1:0] gx_abs, gy_abs;
  logic          g1_xneg_r, g1_yneg_r;
  logic [PW-1:0] g1_xpl_r, g1_xph_r, g1_ypl_r, g1_yph_r;
  logic [1:0]           g1_mode_r, g1_quad_r;
  logic signed [DW-1:0] g1_a_r, g1_b_r;

  assign gx_abs = rot_x_r[N][CW-1] ? CW'(-rot_x_r[N]) : CW'(rot_x_r[N]);
  assign gy_abs = rot_y_r[N][CW-1] ? CW'(-rot_y_r[N]) : CW'(rot_y_r[N]);

  always_ff @(posedge clk) begin
    if (en) begin
      g1_xneg_r <= rot_x_r[N][CW-1];
      g1_yneg_r <= rot_y_r[N][CW-1];
      g1_xpl_r  <= PW'(gx_abs[SPL-1:0]) * GAIN_W;
      g1_xph_r  <= PW'(gx_abs[CW-2:SPL]) * GAIN_W;
      g1_ypl_r  <= PW'(gy_abs[SPL-1:0]) * GAIN_W;
      g1_yph_r  <= PW'(gy_abs[CW-2:SPL]) * GAIN_W;
      g1_mode_r <= rot_mode_r[N];
      g1_quad_r <= rot_quad_r[N];
      g1_a_r    <= rot_a_r[N];
      g1_b_r    <= rot_b_r[N];
    end
  end

  // gain stage 2: combine and round
  logic signed [GRW-1:0] g2_x_r, g2_y_r;
  logic [1:0]            g2_mode_r, g2_quad_r;
  logic signed [DW-1:0]  g2_a_r, g2_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      g2_x_r    <= gain_fin(g1_xneg_r, g1_xph_r, g1_xpl_r);
      g2_y_r    <= gain_fin(g1_yneg_r, g1_yph_r, g1_ypl_r);
      g2_mode_r <= g1_mode_r;
      g2_quad_r <= g1_quad_r;
      g2_a_r    <= g1_a_r;
      g2_b_r    <= g1_b_r;
    end
  end

  // quadrant restore, saturation, rectangular bypass
  logic signed [GRW-1:0] qx, qy;
  logic signed [DW-1:0]  sq_x_nxt, sq_y_nxt;
  logic signed [DW-1:0]  sq_x_r, sq_y_r;
  logic                  sq_err_r;

  always_comb begin
    case (g2_quad_r)
      2'd1: begin
        qx = -g2_y_r;
        qy = g2_x_r;
      end
      2'd2: begin
        qx = -g2_x_r;
        qy = -g2_y_r;
      end
      2'd3: begin
        qx = g2_y_r;
        qy = -g2_x_r;
      end
      default: begin
        qx = g2_x_r;
        qy = g2_y_r;
      end
    endcase
    if (g2_mode_r == prc_pkg::MODE_RECT) begin
      sq_x_nxt = g2_a_r;
      sq_y_nxt = g2_b_r;
    end else begin
      sq_x_nxt = sat_dw(qx);
      sq_y_nxt = sat_dw(qy);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x_r   <= sq_x_nxt;
      sq_y_r   <= sq_y_nxt;
      sq_err_r <= (g2_mode_r != prc_pkg::MODE_RECT) && (g2_mode_r != prc_pkg::MODE_POLAR);
    end
  end

  // vectoring cordic, entry stage folds the left half plane
  logic signed [CW-1:0] px_w, py_w, vx0, vy0;
  logic signed [ZW-1:0] vz0;
  logic signed [CW-1:0] vec_x_r [0:N];
  logic signed [CW-1:0] vec_y_r [0:N];
  logic signed [ZW-1:0] vec_z_r [0:N];
  logic signed [DW-1:0] vec_xo_r [0:N];
  logic signed [DW-1:0] vec_yo_r [0:N];
  logic                 vec_org_r [0:N];
  logic                 vec_err_r [0:N];

  always_comb begin
    px_w = CW'(sq_x_r);
    py_w = CW'(sq_y_r);
    if (sq_x_r[DW-1]) begin
      if (!sq_y_r[DW-1]) begin
        vx0 = py_w;
        vy0 = -px_w;
        vz0 = HALF_PI;
      end else begin
        vx0 = -py_w;
        vy0 = px_w;
        vz0 = -HALF_PI;
      end
    end else begin
      vx0 = px_w;
      vy0 = py_w;
      vz0 = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_x_r[0]   <= vx0 <<< GB;
      vec_y_r[0]   <= vy0 <<< GB;
      vec_z_r[0]   <= vz0;
      vec_xo_r[0]  <= sq_x_r;
      vec_yo_r[0]  <= sq_y_r;
      vec_org_r[0] <= (sq_x_r == '0) && (sq_y_r == '0);
      vec_err_r[0] <= sq_err_r;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_vec
    localparam logic signed [ZW-1:0] ATAN = ZW'(prc_pkg::ATAN_TAB[i]);
    logic signed [CW-1:0] dx, dy;

    assign dx = vec_y_r[i] >>> i;
    assign dy = vec_x_r[i] >>> i;

    // drive y toward zero, accumulate angle
    always_ff @(posedge clk) begin
      if (en) begin
        if (!vec_y_r[i][CW-1]) begin
          vec_x_r[i+1] <= vec_x_r[i] + dx;
          vec_y_r[i+1] <= vec_y_r[i] - dy;
          vec_z_r[i+1] <= vec_z_r[i] + ATAN;
        end else begin
          vec_x_r[i+1] <= vec_x_r[i] - dx;
          vec_y_r[i+1] <= vec_y_r[i] + dy;
          vec_z_r[i+1] <= vec_z_r[i] - ATAN;
        end
        vec_xo_r[i+1]  <= vec_xo_r[i];
        vec_yo_r[i+1]  <= vec_yo_r[i];
        vec_org_r[i+1] <= vec_org_r[i];
        vec_err_r[i+1] <= vec_err_r[i];
      end
    end
  end

  // final stage 1: magnitude partial products, angle round and clamp
  logic [CW-1:0]         fm_abs;
  logic signed [ZW-1:0]  fz;
  logic signed [ZW-15:0] fang;
  logic signed [AW-1:0]  f1_ang_nxt;
  logic                  f1_neg_r;
  logic [PW-1:0]         f1_pl_r, f1_ph_r;
  logic signed [AW-1:0]  f1_ang_r;
  logic signed [DW-1:0]  f1_x_r, f1_y_r;
  logic                  f1_org_r, f1_err_r;

  always_comb begin
    fm_abs = vec_x_r[N][CW-1] ? CW'(-vec_x_r[N]) : CW'(vec_x_r[N]);
    fz     = vec_z_r[N] + ZRND;
    fang   = (ZW-14)'(fz >>> 14);
    if (fang > prc_pkg::ANG_MAX) begin
      f1_ang_nxt = AW'(prc_pkg::ANG_MAX);
    end else if (fang < -prc_pkg::ANG_MAX) begin
      f1_ang_nxt = AW'(-prc_pkg::ANG_MAX);
    end else begin
      f1_ang_nxt = AW'(fang);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_neg_r <= vec_x_r[N][CW-1];
      f1_pl_r  <= PW'(fm_abs[SPL-1:0]) * GAIN_W;
      f1_ph_r  <= PW'(fm_abs[CW-2:SPL]) * GAIN_W;
      f1_ang_r <= f1_ang_nxt;
      f1_x_r   <= vec_xo_r[N];
      f1_y_r   <= vec_yo_r[N];
      f1_org_r <= vec_org_r[N];
      f1_err_r <= vec_err_r[N];
    end
  end

  // output register: magnitude clamp, origin and invalid form handling
  logic signed [GRW-1:0] fm;
  logic [DW-1:0]         mag_nxt;
  logic signed [DW-1:0]  out_x_r, out_y_r;
  logic [DW-1:0]         out_mag_r;
  logic signed [AW-1:0]  out_ang_r;
  logic                  out_err_r;

  always_comb begin
    fm = gain_fin(f1_neg_r, f1_ph_r, f1_pl_r);
    if (fm < 0) begin
      mag_nxt = '0;
    end else if (fm[GRW-1:DW] != '0) begin
      mag_nxt = '1;
    end else begin
      mag_nxt = fm[DW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (f1_err_r) begin
        out_x_r   <= '0;
        out_y_r   <= '0;
        out_mag_r <= '0;
        out_ang_r <= '0;
        out_err_r <= 1'b1;
      end else begin
        out_x_r   <= f1_x_r;
        out_y_r   <= f1_y_r;
        out_mag_r <= f1_org_r ? '0 : mag_nxt;
        out_ang_r <= f1_org_r ? '0 : f1_ang_r;
        out_err_r <= 1'b0;
      end
    end
  end

  assign out_x_out      = out_x_r;
  assign out_y_out      = out_y_r;
  assign out_magnitude  = out_mag_r;
  assign out_angle_rad  = out_ang_r;
  assign out_form_error = out_err_r;

endmodule

[hw/rtl/prc_checker.sv]
// ----------------------------------------------------------------------------
// prc_checker
// Port-level checks for the polar/rectangular converter, bound to the top.
// ----------------------------------------------------------------------------
module prc_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [prc_pkg::DATA_WIDTH-1:0] out_x_out,
  input logic signed [prc_pkg::DATA_WIDTH-1:0] out_y_out,
  input logic [prc_pkg::DATA_WIDTH-1:0]        out_magnitude,
  input logic signed [prc_pkg::ANG_WIDTH-1:0]  out_angle_rad,
  input logic                                  out_form_error
);

  // reset empties the pipeline
  a_reset_empties: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // input side only backs up when a result is held at the output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a stalled result");

  // invalid form gives an all-zero transaction
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_form_error) |->
      (out_x_out == '0 && out_y_out == '0 && out_magnitude == '0 && out_angle_rad == '0))
    else $error("form_error transaction carries nonzero fields");

  // angle stays within +-pi
  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (out_angle_rad <= prc_pkg::ANG_MAX && out_angle_rad >= -prc_pkg::ANG_MAX))
    else $error("angle out of range");

  // a stalled result stays valid and keeps its x, magnitude and angle
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_x_out) && $stable(out_magnitude)
       && $stable(out_angle_rad)))
    else $error("stalled result changed");

endmodule

bind polar_rect_converter prc_checker u_prc_checker (.*);

[tb/tb_polar_rect_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polar_rect_converter
// Self-checking bench for the polar/rectangular converter. Directed vectors
// cover the field extremes, both input forms, invalid forms, the origin,
// negative polar magnitude, large angles and saturation. These are followed
// by random vectors. A bit-exact CORDIC predictor supplies the expected x,
// y, magnitude, angle and error flag for every transaction. The sender
// idles in random bursts and the receiver stalls in a pattern of its own.
// ----------------------------------------------------------------------------
module tb_polar_rect_converter;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] first;
    logic [31:0] second;
  } vec_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] mag;
    logic [18:0] ang;
    logic        err;
  } conv_t;

  localparam longint DEG_FULL_Q = 64'd23592960;
  localparam longint DEG_QTR_Q  = 64'd5898240;
  localparam longint HALF_PI    = 64'd1686629713;
  localparam int     LIMIT      = 1500000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_mode = '0;
  logic signed [31:0] in_first_value = '0;
  logic signed [31:0] in_second_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_x_out, out_y_out;
  logic [31:0] out_magnitude;
  logic signed [18:0] out_angle_rad;
  logic out_form_error;

  vec_t  pending_vecs[$];
  conv_t expected_convs[$];
  int    mismatches = 0;
  int    cycles = 0;
  int    burst_left = 0, gap_left = 0, stall_phase = 0;
  bit    hold_until_drained = 1'b0;
  bit    stim_done = 1'b0;

  polar_rect_converter uut (.*);

  always #5 clk = ~clk;

  // cordic arithmetic helpers
  function automatic longint gain_scale(longint v);
    logic [127:0] p;
    longint a;
    a = v < 0 ? -v : v;
    p = 128'(a) * 128'(prc_pkg::GAIN_Q30) + (128'd1 << 37);
    p = p >> 38;
    return v < 0 ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint sat32(longint v);
    return v > 64'sd2147483647 ? 64'sd2147483647 :
           (v < -64'sd2147483648 ? -64'sd2147483648 : v);
  endfunction

  // bit-exact conversion of one vector
  function automatic conv_t convert(vec_t v);
    conv_t r;
    longint a, b, x, y, rem, f, z, cx, cy, dx, dy, t, m, ang;
    logic [127:0] zp;
    int q;
    r = '{default: '0};
    if (v.mode != prc_pkg::MODE_RECT && v.mode != prc_pkg::MODE_POLAR) begin
      r.err = 1'b1;
      return r;
    end
    a = longint'($signed(v.first));
    b = longint'($signed(v.second));
    if (v.mode == prc_pkg::MODE_RECT) begin
      x = a;
      y = b;
    end else begin
      rem = b % DEG_FULL_Q;
      if (rem < 0) rem += DEG_FULL_Q;
      q = int'(rem / DEG_QTR_Q);
      f = rem - q * DEG_QTR_Q;
      zp = (128'(f) * 128'(prc_pkg::DEG2RAD_C) + (128'd1 << 31)) >> 32;
      z = longint'(zp[63:0]);
      cx = a * 256;
      cy = 0;
      for (int i = 0; i < prc_pkg::ITERS; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (z >= 0) begin
          cx -= dx; cy += dy; z -= longint'(prc_pkg::ATAN_TAB[i]);
        end else begin
          cx += dx; cy -= dy; z += longint'(prc_pkg::ATAN_TAB[i]);
        end
      end
      x = gain_scale(cx);
      y = gain_scale(cy);
      case (q)
        1: begin t = x; x = -y; y = t; end
        2: begin x = -x; y = -y; end
        3: begin t = x; x = y; y = -t; end
        default: ;
      endcase
      x = sat32(x);
      y = sat32(y);
    end
    r.x = x[31:0];
    r.y = y[31:0];
    if (x == 0 && y == 0) return r;
    // vectoring pass, pre-rotated into the right half plane
    z = 0;
    if (x < 0) begin
      if (y >= 0) begin t = x; x = y; y = -t; z = HALF_PI; end
      else begin t = x; x = -y; y = t; z = -HALF_PI; end
    end
    x *= 256;
    y *= 256;
    for (int i = 0; i < prc_pkg::ITERS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx; y -= dy; z += longint'(prc_pkg::ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; z -= longint'(prc_pkg::ATAN_TAB[i]);
      end
    end
    m = gain_scale(x);
    m = m < 0 ? 0 : (m > 64'sd4294967295 ? 64'sd4294967295 : m);
    ang = (z + 8192) >>> 14;
    ang = ang > prc_pkg::ANG_MAX ? prc_pkg::ANG_MAX :
          (ang < -prc_pkg::ANG_MAX ? -prc_pkg::ANG_MAX : ang);
    r.mag = m[31:0];
    r.ang = ang[18:0];
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return 32'($signed($urandom_range(0, 20000000)) - 10000000);
      2: return 32'($signed($urandom_range(0, 1000)) - 500);
      3: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom())};
      default: return 32'($urandom_range(0, 32'h7FFF_FFFF));
    endcase
  endfunction

  // stimulus
  initial begin
    vec_t v;
    logic [31:0] ext[6];
    ext = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000};
    pending_vecs.push_back('{prc_pkg::MODE_RECT, 32'h0, 32'h0});
    pending_vecs.push_back('{prc_pkg::MODE_POLAR, 32'h0, 32'h002D_0000});
    pending_vecs.push_back('{2'd2, 32'h1234_5678, 32'h8765_4321});
    pending_vecs.push_back('{2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
    pending_vecs.push_back('{prc_pkg::MODE_POLAR, 32'hFFFE_0000, 32'h002D_0000});
    pending_vecs.push_back('{prc_pkg::MODE_POLAR, 32'h7FFF_FFFF, 32'h002D_0000});
    pending_vecs.push_back('{prc_pkg::MODE_POLAR, 32'h8000_0000, 32'hFFD3_0000});
    pending_vecs.push_back('{prc_pkg::MODE_POLAR, 32'h0001_0000, 32'h7FFF_FFFF});
    pending_vecs.push_back('{prc_pkg::MODE_POLAR, 32'h0001_0000, 32'h8000_0000});
    pending_vecs.push_back('{prc_pkg::MODE_POLAR, 32'h0001_0000, 32'h0168_0000});
    pending_vecs.push_back('{prc_pkg::MODE_POLAR, 32'h0001_0000, 32'h005A_0000});
    pending_vecs.push_back('{prc_pkg::MODE_RECT, 32'h0, 32'hFFFF_0000});
    pending_vecs.push_back('{prc_pkg::MODE_RECT, 32'hFFFF_0000, 32'h0});
    pending_vecs.push_back('{prc_pkg::MODE_RECT, 32'hFFFF_0000, 32'hFFFF_FFFF});
    for (int i = 0; i < 6; i++)
      pending_vecs.push_back('{prc_pkg::MODE_RECT, ext[i], ext[5 - i]});
    pending_vecs.push_back('{prc_pkg::MODE_RECT, 32'h8000_0000, 32'h8000_0000});
    pending_vecs.push_back('{prc_pkg::MODE_RECT, 32'h7FFF_FFFF, 32'h7FFF_FFFF});
    pending_vecs.push_back('{prc_pkg::MODE_RECT, 32'h8000_0000, 32'h7FFF_FFFF});
    for (int i = 0; i < 1650; i++) begin
      v.mode = $urandom_range(0, 9) < 1 ? 2'($urandom_range(2, 3)) : 2'($urandom_range(0, 1));
      v.first = rand_word();
      v.second = rand_word();
      pending_vecs.push_back(v);
    end
  end

  // reset and clock count
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == 11) rst_n <= 1'b1;
  end

  // driver: random bursts and gaps, one drain pause midway
  always @(posedge clk) begin
    if (rst_n) begin
      automatic bit take = in_valid && !in_stall;
      automatic bit ready_next;
      if (take) expected_convs.push_back(convert('{in_mode, in_first_value, in_second_value}));
      if (!in_valid || take) begin
        if (pending_vecs.size() == 800 && !hold_until_drained && take)
          hold_until_drained <= 1'b1;
        ready_next = pending_vecs.size() > 0 && gap_left == 0 &&
                     !(hold_until_drained && expected_convs.size() > 0);
        if (hold_until_drained && expected_convs.size() == 0) hold_until_drained <= 1'b0;
        if (gap_left > 0) gap_left <= gap_left - 1;
        if (ready_next) begin
          automatic vec_t v = pending_vecs.pop_front();
          in_valid <= 1'b1;
          in_mode <= v.mode;
          in_first_value <= v.first;
          in_second_value <= v.second;
          if (burst_left == 0) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
          end else
            burst_left <= burst_left - 1;
        end else begin
          in_valid <= 1'b0;
          if (pending_vecs.size() == 0) stim_done <= 1'b1;
        end
      end
    end
  end

  // receiver stall pattern: phases of free flow and heavy stalling
  always @(posedge clk) begin
    stall_phase <= (stall_phase + 1) % 600;
    if (stall_phase < 150) out_stall <= 1'b0;
    else if (stall_phase < 350) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= ($urandom_range(0, 1) == 0);
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_convs.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("unexpected result transaction at cycle %0d", cycles);
      end else begin
        automatic conv_t e = expected_convs.pop_front();
        if (e.x !== out_x_out || e.y !== out_y_out || e.mag !== out_magnitude ||
            e.ang !== out_angle_rad || e.err !== out_form_error) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10)
            $display("mismatch: exp x=%h y=%h m=%h a=%h e=%b got x=%h y=%h m=%h a=%h e=%b",
                     e.x, e.y, e.mag, e.ang, e.err, out_x_out, out_y_out,
                     out_magnitude, out_angle_rad, out_form_error);
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done && expected_convs.size() == 0);
    repeat (150) @(posedge clk);
    if (mismatches == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  // timeout
  initial begin
    wait (cycles >= LIMIT);
    $display("== FAIL ==");
    $finish;
  end
endmodule
